[hw/rtl/grouped_mean_accumulator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grouped mean accumulator core
// Concurrent checks on a clock and an active-low reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GROUPED_MEAN_ACCUMULATOR_CORE_ASSERT_SVH
`define GROUPED_MEAN_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define GMA_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
        else $error(msg);
// Check that a condition never occurs out of reset
`define GMA_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
        else $error(msg);
`else
`define GMA_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define GMA_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif
`endif

[hw/rtl/gma_pkg.sv]
// ----------------------------------------------------------------------------
// gma_pkg
// Shared widths, limits and the queue beat type of the grouped mean core.
// ----------------------------------------------------------------------------
`default_nettype none

package gma_pkg;

    // Field widths
    localparam int VALUE_BITS = 32;
    localparam int LABEL_BITS = 7;

    // Table geometry
    localparam int GROUPS     = 64;
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = 48;
    localparam int IDX_BITS   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ENTRY_BITS = SUM_BITS + COUNT_BITS;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Divider step counter
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

    // Saturation limits
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [VALUE_BITS-1:0] MEAN_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] MEAN_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // One classified item as it travels from front to back
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] sample_value;
        logic [IDX_BITS-1:0]          idx;
        logic                         lbl_ok;
        logic                         last;
        logic [LABEL_BITS-1:0]        n;
    } gma_item_t;

endpackage

`default_nettype wire

[hw/rtl/grouped_mean_accumulator_core.sv]
// ----------------------------------------------------------------------------
// grouped_mean_accumulator_core
// Group-by mean over a stream of labelled signed Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: sample_value, group_label, last_item, taken on a rising edge
//   with start high and busy low. Labels of 0, above 64 or above a nonzero
//   group_count are ignored. A four-deep queue parts the input from the
//   table engine, so busy rises only once four items wait.
//   Each item is a read-modify-write of the sum/count memory; the engine
//   takes the next item only after the write. After a last item the groups
//   are scanned in ascending order; each non-empty group is divided by the
//   bit-serial 48-step divider. Each mean is strobed on result_valid for
//   one cycle; the final one carries last_result. With no non-empty group a
//   single result with empty_set is given. The receiver cannot stall.
//   group_count is written over cfg_valid/cfg_data (cfg_ready always high);
//   the user must write it only while the block is idle; the block does not
//   enforce it. Reset clears the tables at once through per group valid
//   bits, zeroes group_count and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_mean_accumulator_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [gma_pkg::VALUE_BITS-1:0] sample_value,
    input  wire logic [gma_pkg::LABEL_BITS-1:0]        group_label,
    input  wire logic                                  last_item,
    output logic                                       result_valid,
    output logic signed [gma_pkg::VALUE_BITS-1:0]      group_mean,
    output logic [gma_pkg::LABEL_BITS-1:0]             group_number,
    output logic                                       empty_set,
    output logic                                       last_result,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gma_pkg::LABEL_BITS-1:0]        cfg_data
);

    gma_pkg::gma_item_t front_item;
    gma_pkg::gma_item_t q_head;
    logic               q_empty;
    logic               q_full;
    logic               q_pop;
    logic               accept;

    // Accept while the queue has room; configuration is always taken
    assign busy      = q_full;
    assign accept    = start && !q_full;
    assign cfg_ready = 1'b1;

    gma_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .sample_value (sample_value),
        .group_label  (group_label),
        .last_item    (last_item),
        .item         (front_item)
    );

    gma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    gma_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .group_mean   (group_mean),
        .group_number (group_number),
        .empty_set    (empty_set),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

[hw/rtl/gma_ram.sv]
// ----------------------------------------------------------------------------
// gma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/gma_front.sv]
// ----------------------------------------------------------------------------
// gma_front
// Holds the group count register, checks labels, tracks the largest label
// and builds the queue beat, including the report length on a last item.
// ----------------------------------------------------------------------------
`default_nettype none

module gma_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_wr,
    input  wire logic [gma_pkg::LABEL_BITS-1:0]          cfg_data,
    input  wire logic                                    accept,
    input  wire logic signed [gma_pkg::VALUE_BITS-1:0]   sample_value,
    input  wire logic [gma_pkg::LABEL_BITS-1:0]          group_label,
    input  wire logic                                    last_item,
    output gma_pkg::gma_item_t                           item
);

    logic [gma_pkg::LABEL_BITS-1:0] group_count_reg;
    logic [gma_pkg::LABEL_BITS-1:0] largest_reg;
    logic [gma_pkg::LABEL_BITS-1:0] largest_next;
    logic [gma_pkg::LABEL_BITS-1:0] largest_upd;
    logic [gma_pkg::LABEL_BITS-1:0] lbl_m1;
    logic [gma_pkg::LABEL_BITS-1:0] n_raw;
    logic                           lbl_ok;

    localparam logic [gma_pkg::LABEL_BITS-1:0] GROUPS_L =
        gma_pkg::LABEL_BITS'(gma_pkg::GROUPS);

    // Classify the label against table size and group count
    always_comb
    begin
        lbl_ok = (group_label != '0) && (group_label <= GROUPS_L) &&
                 ((group_count_reg == '0) || (group_label <= group_count_reg));
        lbl_m1 = group_label - gma_pkg::LABEL_BITS'(1);
        largest_upd = (lbl_ok && (group_label > largest_reg)) ? group_label : largest_reg;
        n_raw = (group_count_reg != '0) ? group_count_reg : largest_upd;
    end

    // Build the beat for the queue
    always_comb
    begin
        item.sample_value = sample_value;
        item.idx          = lbl_m1[gma_pkg::IDX_BITS-1:0];
        item.lbl_ok       = lbl_ok;
        item.last         = last_item;
        item.n            = (n_raw > GROUPS_L) ? GROUPS_L : n_raw;
    end

    // Advance the largest label; drop it once a run closes
    always_comb
    begin
        largest_next = largest_reg;
        if (accept)
        begin
            largest_next = last_item ? '0 : largest_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= '0;
            largest_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                group_count_reg <= cfg_data;
            end
            largest_reg <= largest_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gma_queue.sv]
// ----------------------------------------------------------------------------
// gma_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gma_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gma_pkg::gma_item_t push_item,
    input  wire logic               pop,
    output gma_pkg::gma_item_t      head,
    output logic                    empty,
    output logic                    full
);

    gma_pkg::gma_item_t slot_reg [gma_pkg::QUEUE_DEPTH];

    logic [gma_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [gma_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [gma_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [gma_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [gma_pkg::QPTR_BITS:0]   fill_reg;
    logic [gma_pkg::QPTR_BITS:0]   fill_next;

    localparam logic [gma_pkg::QPTR_BITS-1:0] PTR_LAST =
        gma_pkg::QPTR_BITS'(gma_pkg::QUEUE_DEPTH - 1);
    localparam logic [gma_pkg::QPTR_BITS:0] FILL_FULL =
        (gma_pkg::QPTR_BITS + 1)'(gma_pkg::QUEUE_DEPTH);

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == FILL_FULL);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gma_div.sv]
// ----------------------------------------------------------------------------
// gma_div
// Bit-serial restoring divider: signed sum by unsigned count, quotient
// truncated toward zero and saturated to the mean width.
// ----------------------------------------------------------------------------
`default_nettype none

module gma_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [gma_pkg::SUM_BITS-1:0]   dividend,
    input  wire logic [gma_pkg::COUNT_BITS-1:0]        divisor,
    output logic                                       done,
    output logic signed [gma_pkg::VALUE_BITS-1:0]      quotient
);

    localparam int SB = gma_pkg::SUM_BITS;
    localparam int CB = gma_pkg::COUNT_BITS;
    localparam int VB = gma_pkg::VALUE_BITS;
    localparam logic [gma_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
        gma_pkg::DIV_CNT_BITS'(SB - 1);

    logic                            run_reg;
    logic                            fin_reg;
    logic                            done_reg;
    logic [gma_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [SB-1:0]                   quo_reg;
    logic [SB-1:0]                   quo_next;
    logic [CB-1:0]                   rem_reg;
    logic [CB-1:0]                   rem_next;
    logic [CB-1:0]                   div_reg;
    logic                            neg_reg;
    logic signed [VB-1:0]            q_out_reg;
    logic signed [VB-1:0]            q_sat;
    logic [CB:0]                     trial;
    logic [CB:0]                     trial_sub;
    logic [SB-1:0]                   mag_in;

    assign done     = done_reg;
    assign quotient = q_out_reg;

    // Magnitude of the incoming sum
    assign mag_in = dividend[SB-1] ? (SB)'(-dividend) : (SB)'(dividend);

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SB-1]};
        trial_sub = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial_sub[CB-1:0];
            quo_next = {quo_reg[SB-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CB-1:0];
            quo_next = {quo_reg[SB-2:0], 1'b0};
        end
    end

    // Apply the sign and clamp to the mean range
    always_comb
    begin
        if (!neg_reg)
        begin
            q_sat = (|quo_reg[SB-1:VB-1]) ? gma_pkg::MEAN_MAX : $signed(quo_reg[VB-1:0]);
        end
        else if ((|quo_reg[SB-1:VB]) || (quo_reg[VB-1] && (|quo_reg[VB-2:0])))
        begin
            q_sat = gma_pkg::MEAN_MIN;
        end
        else
        begin
            q_sat = $signed(-quo_reg[VB-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag_in;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[SB-1];
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (fin_reg)
        begin
            q_out_reg <= q_sat;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gma_back.sv]
// ----------------------------------------------------------------------------
// gma_back
// Applies queued items to the sum and count table, then on a last item scans
// the groups, divides each non-empty one and strobes out the means.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grouped_mean_accumulator_core_assert.svh"

module gma_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire gma_pkg::gma_item_t                   q_head,
    input  wire logic                                 q_empty,
    output logic                                      q_pop,
    output logic                                      result_valid,
    output logic signed [gma_pkg::VALUE_BITS-1:0]     group_mean,
    output logic [gma_pkg::LABEL_BITS-1:0]            group_number,
    output logic                                      empty_set,
    output logic                                      last_result
);

    localparam int SB = gma_pkg::SUM_BITS;
    localparam int CB = gma_pkg::COUNT_BITS;
    localparam int LB = gma_pkg::LABEL_BITS;
    localparam int GR = gma_pkg::GROUPS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    gma_pkg::gma_item_t      item_reg;
    gma_pkg::gma_item_t      item_next;
    logic [GR-1:0]           valid_reg;
    logic [GR-1:0]           valid_next;
    logic [LB-1:0]           g_reg;
    logic [LB-1:0]           g_next;
    logic [LB-1:0]           n_reg;
    logic [LB-1:0]           n_next;
    logic                    found_reg;
    logic                    found_next;

    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic signed [gma_pkg::VALUE_BITS-1:0] group_mean_reg;
    logic signed [gma_pkg::VALUE_BITS-1:0] group_mean_next;
    logic [LB-1:0]           group_number_reg;
    logic [LB-1:0]           group_number_next;
    logic                    empty_set_reg;
    logic                    empty_set_next;
    logic                    last_result_reg;
    logic                    last_result_next;

    logic                        ram_we;
    logic [gma_pkg::IDX_BITS-1:0] ram_rd_addr;
    logic [gma_pkg::ENTRY_BITS-1:0] ram_wr_data;
    logic [gma_pkg::ENTRY_BITS-1:0] ram_rd_data;

    logic signed [SB-1:0]    old_sum;
    logic [CB-1:0]           old_cnt;
    logic signed [SB:0]      sum_wide;
    logic signed [SB-1:0]    sum_new;
    logic [CB-1:0]           cnt_new;

    logic                    div_start;
    logic                    div_done;
    logic signed [gma_pkg::VALUE_BITS-1:0] div_q;

    logic [GR-1:0]           rest_mask;
    logic                    more_left;

    assign result_valid = result_valid_reg;
    assign group_mean   = group_mean_reg;
    assign group_number = group_number_reg;
    assign empty_set    = empty_set_reg;
    assign last_result  = last_result_reg;

    // Sum and count table, one entry per group
    gma_ram #(
        .WIDTH (gma_pkg::ENTRY_BITS),
        .DEPTH (GR)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (item_reg.idx),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared divider for the means
    gma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ($signed(ram_rd_data[gma_pkg::ENTRY_BITS-1:CB])),
        .divisor  (ram_rd_data[CB-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Read-modify-write arithmetic; an entry not yet valid reads as zero
    always_comb
    begin
        old_sum = valid_reg[item_reg.idx] ? $signed(ram_rd_data[gma_pkg::ENTRY_BITS-1:CB])
                                          : '0;
        old_cnt = valid_reg[item_reg.idx] ? ram_rd_data[CB-1:0] : '0;
        sum_wide = (SB + 1)'(old_sum) + (SB + 1)'(item_reg.sample_value);
        if (sum_wide[SB] != sum_wide[SB-1])
        begin
            sum_new = sum_wide[SB] ? gma_pkg::SUM_MIN : gma_pkg::SUM_MAX;
        end
        else
        begin
            sum_new = sum_wide[SB-1:0];
        end
        cnt_new = (old_cnt == gma_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
        ram_wr_data = {sum_new, cnt_new};
    end

    // Non-empty groups still ahead in this scan
    always_comb
    begin
        for (int i = 0; i < GR; i++)
        begin
            rest_mask[i] = (LB'(i) > g_reg) && (LB'(i) < n_reg);
        end
        more_left = |(valid_reg & rest_mask);
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        valid_next        = valid_reg;
        g_next            = g_reg;
        n_next            = n_reg;
        found_next        = found_reg;
        result_valid_next = 1'b0;
        group_mean_next   = group_mean_reg;
        group_number_next = group_number_reg;
        empty_set_next    = empty_set_reg;
        last_result_next  = last_result_reg;
        q_pop             = 1'b0;
        ram_we            = 1'b0;
        div_start         = 1'b0;
        ram_rd_addr       = g_reg[gma_pkg::IDX_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr = q_head.idx;
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_head;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (item_reg.lbl_ok)
                begin
                    ram_we                   = 1'b1;
                    valid_next[item_reg.idx] = 1'b1;
                end
                if (item_reg.last)
                begin
                    g_next     = '0;
                    n_next     = item_reg.n;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (g_reg >= n_reg)
                begin
                    // Close the run: report an empty set if no group was found, clear the table
                    if (!found_reg)
                    begin
                        result_valid_next = 1'b1;
                        group_mean_next   = '0;
                        group_number_next = '0;
                        empty_set_next    = 1'b1;
                        last_result_next  = 1'b1;
                    end
                    valid_next = '0;
                    state_next = ST_IDLE;
                end
                else if (valid_reg[g_reg[gma_pkg::IDX_BITS-1:0]])
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    g_next = g_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_valid_next = 1'b1;
                    group_mean_next   = div_q;
                    group_number_next = g_reg + 1'b1;
                    empty_set_next    = 1'b0;
                    last_result_next  = !more_left;
                    found_next        = 1'b1;
                    g_next            = g_reg + 1'b1;
                    state_next        = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            g_reg            <= '0;
            n_reg            <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            g_reg            <= g_next;
            n_reg            <= n_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        group_mean_reg   <= group_mean_next;
        group_number_reg <= group_number_next;
        empty_set_reg    <= empty_set_next;
        last_result_reg  <= last_result_next;
    end

    // Checks
    `GMA_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> (state_reg == ST_DIV), "divider finished outside its wait state")
    `GMA_ASSERT(a_clear_after_scan, clk, rst_n, (state_reg == ST_SCAN && g_reg >= n_reg) |=> (valid_reg == '0), "table not cleared at end of run")
    `GMA_ASSERT(a_number_in_range, clk, rst_n, (result_valid_reg && !empty_set_reg) |-> (group_number_reg != '0 && group_number_reg <= n_reg), "reported group outside scan range")
    `GMA_ASSERT_NEVER(a_empty_after_found, clk, rst_n, result_valid_reg && empty_set_reg && found_reg, "empty result after a non-empty group")

endmodule

`default_nettype wire
